@@ hdl/dnsa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnsa_pkg
// Shared types and constants for the DNS answer A-record extractor.
// ----------------------------------------------------------------------------
package dnsa_pkg;

  localparam int unsigned CfgAddrWidth = 3;

  // Register index taken from the word address bits of paddr.
  localparam logic REG_DEFAULT_TTL = 1'b0;

  localparam logic [31:0] TTL_RESET = 32'd300;
  localparam logic [7:0]  PTR_MARK  = 8'hC0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        record_valid;
    logic [31:0] ipv4_address;
    logic [31:0] record_ttl;
    logic [15:0] answer_index;
    logic        packet_end;
    logic        end_status;
  } result_t;

  // Held beat handed from the input register to the parser.
  typedef struct packed {
    logic  valid;
    item_t item;
  } held_item_t;

endpackage
`default_nettype wire

@@ hdl/dns_answer_a_record_extractor_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dns_answer_a_record_extractor_unit
// Streams a DNS response byte by byte and reports IPv4 A records.
// ----------------------------------------------------------------------------
// One packet byte is taken every cycle unless stalled, with no gaps between
// packets. A byte passes an input register and then the parser, whose single
// state update per byte loads the result register. Results come only for a
// completed A record or for the packet's last byte (both share one beat).
// Backpressure on the result side holds the result register and then the
// input register. The default TTL register at byte address 0 is written over
// the APB-style port; the user must do so only while no packet is in flight,
// unenforced by the block. No memory is used and no start-up pass runs.
// ----------------------------------------------------------------------------
module dns_answer_a_record_extractor_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire dnsa_pkg::item_t                   item,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output dnsa_pkg::result_t                      result,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dnsa_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);
  import dnsa_pkg::*;

  logic        take;
  held_item_t  held;
  logic [31:0] default_ttl;

  dnsa_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .default_ttl (default_ttl)
  );

  dnsa_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .take       (take),
    .held       (held)
  );

  dnsa_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .held         (held),
    .take         (take),
    .default_ttl  (default_ttl),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

@@ hdl/dnsa_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnsa_cfg_regs
// APB-style register file holding the default TTL.
// ----------------------------------------------------------------------------
module dnsa_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dnsa_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  output logic      [31:0]                       default_ttl
);
  import dnsa_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_ttl <= TTL_RESET;
    end else if (wr_en && (paddr[CfgAddrWidth-1] == REG_DEFAULT_TTL)) begin
      default_ttl <= pwdata;
    end
  end

  always_comb begin
    if (paddr[CfgAddrWidth-1] == REG_DEFAULT_TTL) begin
      prdata = default_ttl;
    end else begin
      prdata = 32'd0;
    end
  end

endmodule
`default_nettype wire

@@ hdl/dnsa_in_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnsa_in_stage
// Input register: holds one packet byte until the parser takes it.
// ----------------------------------------------------------------------------
module dnsa_in_stage (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    item_valid,
  output logic                         item_stall,
  input  wire dnsa_pkg::item_t         item,
  input  wire logic                    take,
  output dnsa_pkg::held_item_t         held
);
  import dnsa_pkg::*;

  logic  hold_valid;
  item_t hold_item;

  // Stall only while a held beat cannot move on this cycle.
  assign item_stall = hold_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!item_stall) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      hold_item <= item;
    end
  end

  assign held.valid = hold_valid;
  assign held.item  = hold_item;

endmodule
`default_nettype wire

@@ hdl/dnsa_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnsa_parser
// Byte-wise DNS response walker with a registered result stage.
// ----------------------------------------------------------------------------
module dnsa_parser (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire dnsa_pkg::held_item_t   held,
  output logic                        take,
  input  wire logic [31:0]            default_ttl,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output dnsa_pkg::result_t           result
);
  import dnsa_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_QNAME,
    PH_QPTR,
    PH_QFIXED,
    PH_ANAME,
    PH_APTR,
    PH_AFIXED,
    PH_ADATA,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [7:0]  label_left, label_left_next;
  logic [15:0] questions_left, questions_left_next;
  logic [15:0] answers_left, answers_left_next;
  logic [15:0] answer_number, answer_number_next;
  logic [15:0] record_type, record_type_next;
  logic [15:0] data_left, data_left_next;
  logic [31:0] ttl_accum, ttl_accum_next;
  logic [31:0] addr_accum, addr_accum_next;

  logic [7:0]  b;
  logic        last;
  logic        rec;
  logic        emit;
  logic [3:0]  data_count;
  result_t     result_next;

  assign b    = held.item.data_byte;
  assign last = held.item.last_byte;
  assign take = held.valid && (!result_valid || !result_stall);

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    label_left_next     = label_left;
    questions_left_next = questions_left;
    answers_left_next   = answers_left;
    answer_number_next  = answer_number;
    record_type_next    = record_type;
    data_left_next      = data_left;
    ttl_accum_next      = ttl_accum;
    addr_accum_next     = addr_accum;
    rec                 = 1'b0;
    data_count          = (byte_count < 4'd15) ? byte_count + 4'd1 : byte_count;

    unique case (phase)
      PH_HEADER: begin
        if (byte_count == 4'd4 || byte_count == 4'd5) begin
          questions_left_next = {questions_left[7:0], b};
        end else if (byte_count == 4'd6 || byte_count == 4'd7) begin
          answers_left_next = {answers_left[7:0], b};
        end
        if (byte_count >= 4'd11) begin
          byte_count_next = 4'd0;
          label_left_next = 8'd0;
          if (questions_left_next != 16'd0) begin
            phase_next = PH_QNAME;
          end else if (answers_left_next != 16'd0) begin
            phase_next = PH_ANAME;
          end else begin
            phase_next = PH_DONE;
          end
        end else begin
          byte_count_next = byte_count + 4'd1;
        end
      end
      PH_QNAME, PH_ANAME: begin
        if (label_left != 8'd0) begin
          label_left_next = label_left - 8'd1;
        end else if (b == 8'd0) begin
          phase_next      = (phase == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
          byte_count_next = 4'd0;
        end else if ((b & PTR_MARK) == PTR_MARK) begin
          phase_next = (phase == PH_QNAME) ? PH_QPTR : PH_APTR;
        end else begin
          label_left_next = b;
        end
      end
      PH_QPTR: begin
        phase_next      = PH_QFIXED;
        byte_count_next = 4'd0;
      end
      PH_APTR: begin
        phase_next      = PH_AFIXED;
        byte_count_next = 4'd0;
      end
      PH_QFIXED: begin
        if (byte_count >= 4'd3) begin
          byte_count_next     = 4'd0;
          questions_left_next = questions_left - 16'd1;
          label_left_next     = 8'd0;
          if (questions_left_next != 16'd0) begin
            phase_next = PH_QNAME;
          end else if (answers_left != 16'd0) begin
            phase_next = PH_ANAME;
          end else begin
            phase_next = PH_DONE;
          end
        end else begin
          byte_count_next = byte_count + 4'd1;
        end
      end
      PH_AFIXED: begin
        if (byte_count <= 4'd1) begin
          record_type_next = {record_type[7:0], b};
        end else if (byte_count >= 4'd4 && byte_count <= 4'd7) begin
          ttl_accum_next = {ttl_accum[23:0], b};
        end else if (byte_count >= 4'd8) begin
          data_left_next = {data_left[7:0], b};
        end
        if (byte_count >= 4'd9) begin
          byte_count_next = 4'd0;
          if (data_left_next == 16'd0) begin
            // Empty record data: the answer ends here.
            answers_left_next  = answers_left - 16'd1;
            answer_number_next = answer_number + 16'd1;
            label_left_next    = 8'd0;
            phase_next         = (answers_left_next != 16'd0) ? PH_ANAME : PH_DONE;
          end else begin
            phase_next = PH_ADATA;
          end
        end else begin
          byte_count_next = byte_count + 4'd1;
        end
      end
      PH_ADATA: begin
        addr_accum_next = {addr_accum[23:0], b};
        byte_count_next = data_count;
        data_left_next  = data_left - 16'd1;
        if (data_left_next == 16'd0) begin
          rec                = (record_type == 16'd1) && (data_count == 4'd4);
          record_type_next   = 16'd0;
          ttl_accum_next     = 32'd0;
          addr_accum_next    = 32'd0;
          byte_count_next    = 4'd0;
          answers_left_next  = answers_left - 16'd1;
          answer_number_next = answer_number + 16'd1;
          label_left_next    = 8'd0;
          phase_next         = (answers_left_next != 16'd0) ? PH_ANAME : PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    emit = rec || last;

    result_next.record_valid = rec;
    result_next.ipv4_address = rec ? {addr_accum[23:0], b} : 32'd0;
    result_next.record_ttl   = !rec ? 32'd0 :
                               (ttl_accum != 32'd0) ? ttl_accum : default_ttl;
    result_next.answer_index = rec ? answer_number : 16'd0;
    result_next.packet_end   = last;
    result_next.end_status   = last && (phase_next != PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      byte_count     <= 4'd0;
      label_left     <= 8'd0;
      questions_left <= 16'd0;
      answers_left   <= 16'd0;
      answer_number  <= 16'd0;
      record_type    <= 16'd0;
      data_left      <= 16'd0;
      ttl_accum      <= 32'd0;
      addr_accum     <= 32'd0;
      result_valid   <= 1'b0;
      result         <= '0;
    end else begin
      if (take) begin
        if (last) begin
          // Packet over: drop all parse state for the next packet.
          phase          <= PH_HEADER;
          byte_count     <= 4'd0;
          label_left     <= 8'd0;
          questions_left <= 16'd0;
          answers_left   <= 16'd0;
          answer_number  <= 16'd0;
          record_type    <= 16'd0;
          data_left      <= 16'd0;
          ttl_accum      <= 32'd0;
          addr_accum     <= 32'd0;
        end else begin
          phase          <= phase_next;
          byte_count     <= byte_count_next;
          label_left     <= label_left_next;
          questions_left <= questions_left_next;
          answers_left   <= answers_left_next;
          answer_number  <= answer_number_next;
          record_type    <= record_type_next;
          data_left      <= data_left_next;
          ttl_accum      <= ttl_accum_next;
          addr_accum     <= addr_accum_next;
        end
        result_valid <= emit;
        if (emit) begin
          result <= result_next;
        end
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/dnsa_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnsa_checker
// Port-level checks for the extractor, bound to the top level.
// ----------------------------------------------------------------------------
module dnsa_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire dnsa_pkg::result_t result
);
  import dnsa_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result beat changed while stalled");

  a_only_record_or_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.record_valid |-> result.packet_end)
    else $error("result beat with neither record nor packet end");

  a_status_at_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.packet_end |-> !result.end_status)
    else $error("end status set away from packet end");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.record_valid |->
      result.ipv4_address == 32'd0 && result.record_ttl == 32'd0 &&
      result.answer_index == 16'd0)
    else $error("record fields set without a record");

endmodule

bind dns_answer_a_record_extractor_unit dnsa_checker u_dnsa_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
`default_nettype wire

@@ bench/dnsa_result_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnsa_result_checker
// Watches the byte and result channels of the DNS A-record extractor, runs
// its own byte-level parser to predict each result, and compares them.
// ----------------------------------------------------------------------------
// Accepted byte beats drive a parser model that keeps its own copy of the
// parse state and of the default TTL (tracked from APB writes). Every
// predicted result is queued and checked field by field against the next
// accepted result beat. Register reads are checked against the tracked value.
// ----------------------------------------------------------------------------
module dnsa_result_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  input  wire logic                              item_stall,
  input  wire dnsa_pkg::item_t                   item,
  input  wire logic                              result_valid,
  input  wire logic                              result_stall,
  input  wire dnsa_pkg::result_t                 result,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dnsa_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                       pwdata,
  input  wire logic [31:0]                       prdata,
  input  wire logic                              pready,
  output int                                     failures,
  output int                                     pending,
  output int                                     n_packets,
  output int                                     n_records,
  output int                                     n_truncated
);
  import dnsa_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_QNAME,
    PH_QPTR,
    PH_QFIXED,
    PH_ANAME,
    PH_APTR,
    PH_AFIXED,
    PH_ADATA,
    PH_DONE
  } parse_phase_t;

  localparam logic [15:0] TYPE_A = 16'd1;
  localparam logic [3:0]  A_LEN  = 4'd4;

  parse_phase_t phase;
  logic [3:0]   cnt;
  logic [7:0]   label_left;
  logic [15:0]  q_left;
  logic [15:0]  a_left;
  logic [15:0]  a_num;
  logic [15:0]  rtype;
  logic [15:0]  dlen_left;
  logic [31:0]  ttl_acc;
  logic [31:0]  addr_acc;
  logic [31:0]  ttl_default;

  result_t expected_results[$];
  result_t want;
  int      fail_total;

  task clear_parser();
    phase      = PH_HEADER;
    cnt        = '0;
    label_left = '0;
    q_left     = '0;
    a_left     = '0;
    a_num      = '0;
    rtype      = '0;
    dlen_left  = '0;
    ttl_acc    = '0;
    addr_acc   = '0;
  endtask

  task enter_answers();
    phase      = (a_left != 0) ? PH_ANAME : PH_DONE;
    label_left = '0;
  endtask

  task enter_questions();
    if (q_left != 0) begin
      phase      = PH_QNAME;
      label_left = '0;
    end else begin
      enter_answers();
    end
  endtask

  task answer_done();
    a_left = a_left - 16'd1;
    a_num  = a_num + 16'd1;
    enter_answers();
  endtask

  // Skip one name byte; a zero byte ends the name, a pointer mark moves on
  // to the pointer's second byte.
  task name_step(input logic [7:0] b, input parse_phase_t ptr_ph, output logic ended);
    ended = 1'b0;
    if (label_left != 0) begin
      label_left = label_left - 8'd1;
    end else if (b == 8'd0) begin
      ended = 1'b1;
    end else if ((b & PTR_MARK) == PTR_MARK) begin
      phase = ptr_ph;
    end else begin
      label_left = b;
    end
  endtask

  task advance_parser(input item_t beat);
    logic [7:0] b;
    logic       ended;
    result_t    r;
    b = beat.data_byte;
    r = '0;
    case (phase)
      PH_HEADER: begin
        if (cnt == 4'd4 || cnt == 4'd5) q_left = {q_left[7:0], b};
        else if (cnt == 4'd6 || cnt == 4'd7) a_left = {a_left[7:0], b};
        if (cnt >= 4'd11) begin
          cnt = '0;
          enter_questions();
        end else begin
          cnt = cnt + 4'd1;
        end
      end
      PH_QNAME: begin
        name_step(b, PH_QPTR, ended);
        if (ended) begin
          phase = PH_QFIXED;
          cnt   = '0;
        end
      end
      PH_QPTR: begin
        phase = PH_QFIXED;
        cnt   = '0;
      end
      PH_QFIXED: begin
        if (cnt >= 4'd3) begin
          cnt    = '0;
          q_left = q_left - 16'd1;
          enter_questions();
        end else begin
          cnt = cnt + 4'd1;
        end
      end
      PH_ANAME: begin
        name_step(b, PH_APTR, ended);
        if (ended) begin
          phase = PH_AFIXED;
          cnt   = '0;
        end
      end
      PH_APTR: begin
        phase = PH_AFIXED;
        cnt   = '0;
      end
      PH_AFIXED: begin
        if (cnt <= 4'd1) rtype = {rtype[7:0], b};
        else if (cnt >= 4'd4 && cnt <= 4'd7) ttl_acc = {ttl_acc[23:0], b};
        else if (cnt >= 4'd8) dlen_left = {dlen_left[7:0], b};
        if (cnt >= 4'd9) begin
          cnt = '0;
          if (dlen_left == 0) answer_done();
          else phase = PH_ADATA;
        end else begin
          cnt = cnt + 4'd1;
        end
      end
      PH_ADATA: begin
        addr_acc = {addr_acc[23:0], b};
        // count saturates so long data never looks like four bytes
        if (cnt < 4'd15) cnt = cnt + 4'd1;
        dlen_left = dlen_left - 16'd1;
        if (dlen_left == 0) begin
          if (rtype == TYPE_A && cnt == A_LEN) begin
            r.record_valid = 1'b1;
            r.ipv4_address = addr_acc;
            r.record_ttl   = (ttl_acc != 0) ? ttl_acc : ttl_default;
            r.answer_index = a_num;
          end
          rtype    = '0;
          ttl_acc  = '0;
          addr_acc = '0;
          cnt      = '0;
          answer_done();
        end
      end
      default: ;
    endcase
    if (r.record_valid || beat.last_byte) begin
      r.packet_end = beat.last_byte;
      r.end_status = beat.last_byte && (phase != PH_DONE);
      expected_results.push_back(r);
      if (r.record_valid) n_records++;
      if (beat.last_byte) begin
        n_packets++;
        if (r.end_status) n_truncated++;
        clear_parser();
      end
    end
  endtask

  task check_field(input string fname, input logic [31:0] exp_val, input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_val, act_val);
      fail_total++;
    end
  endtask

  initial begin
    fail_total  = 0;
    n_packets   = 0;
    n_records   = 0;
    n_truncated = 0;
    failures    = 0;
    pending     = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      ttl_default = TTL_RESET;
      expected_results.delete();
    end else begin
      if (psel && penable && pready && paddr[CfgAddrWidth-1:2] == REG_DEFAULT_TTL) begin
        if (pwrite) begin
          ttl_default = pwdata;
        end else if (prdata !== ttl_default) begin
          $display("%0t: default_ttl readback mismatch, expected %h, actual %h",
                   $time, ttl_default, prdata);
          fail_total++;
        end
      end
      if (item_valid && !item_stall) advance_parser(item);
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, result);
          fail_total++;
        end else begin
          want = expected_results.pop_front();
          check_field("record_valid", 32'(want.record_valid), 32'(result.record_valid));
          check_field("ipv4_address", want.ipv4_address, result.ipv4_address);
          check_field("record_ttl", want.record_ttl, result.record_ttl);
          check_field("answer_index", 32'(want.answer_index), 32'(result.answer_index));
          check_field("packet_end", 32'(want.packet_end), 32'(result.packet_end));
          check_field("end_status", 32'(want.end_status), 32'(result.end_status));
        end
      end
    end
    pending  <= expected_results.size();
    failures <= fail_total;
  end

endmodule
`default_nettype wire

@@ bench/tb_dns_answer_a_record_extractor_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_dns_answer_a_record_extractor_unit
// Stimulus and verdict for the DNS answer A-record extractor.
// ----------------------------------------------------------------------------
// Sends directed packets (lone bytes, empty counts, long labels, pointers
// after labels, wrong types and lengths, zero TTLs, cut-short packets), then
// random packets under four default TTL settings, mostly well formed with
// some noise, truncation and trailing bytes. Both channels idle in random
// bursts and the result side holds off once for a long stretch. A separate
// checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_dns_answer_a_record_extractor_unit;
  import dnsa_pkg::*;

  localparam int ClkHalf       = 6;
  localparam int TimeoutCycles = 800000;
  localparam int ByteTarget    = 1750;
  localparam int HoldCycles    = 300;
  localparam int DrainLimit    = 5000;
  localparam int TailCycles    = 6;

  localparam logic [15:0]             TYPE_A  = 16'd1;
  localparam logic [15:0]             TYPE_AAAA = 16'd28;
  localparam logic [CfgAddrWidth-1:0] TtlAddr = {REG_DEFAULT_TTL, 2'b00};

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  item_t             item         = '0;
  logic              result_stall = 1'b0;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [CfgAddrWidth-1:0] paddr  = '0;
  logic [31:0]       pwdata       = '0;
  logic              item_stall;
  logic              result_valid;
  result_t           result;
  logic [31:0]       prdata;
  logic              pready;

  int failures, pending, n_packets, n_records, n_truncated;

  logic [7:0] pkt[$];
  int         bytes_sent  = 0;
  bit         tx_idle_on  = 1'b1;
  logic       rx_idle_on  = 1'b0;
  logic       rx_hold_req = 1'b0;
  int         hold_left   = 0;
  int         burst_left  = 0;
  bit         hold_taken  = 1'b0;

  dns_answer_a_record_extractor_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  dnsa_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .failures     (failures),
    .pending      (pending),
    .n_packets    (n_packets),
    .n_records    (n_records),
    .n_truncated  (n_truncated)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // Result side: one long hold on request, otherwise random stall bursts.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (rx_hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HoldCycles - 1;
      result_stall <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left--;
      result_stall <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(1, 7) - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task cfg_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TtlAddr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // return to idle between transfers
    @(posedge clk);
  endtask

  task send_beat(input item_t beat);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item       <= beat;
    item_valid <= 1'b1;
    @(posedge clk);
    // hold the beat until the block takes it
    while (item_stall) @(posedge clk);
  endtask

  task send_packet();
    item_t beat;
    for (int i = 0; i < pkt.size(); i++) begin
      beat.data_byte = pkt[i];
      beat.last_byte = (i == pkt.size() - 1);
      send_beat(beat);
    end
    bytes_sent += pkt.size();
    pkt.delete();
  endtask

  task add_bytes(input int n);
    repeat (n) pkt.push_back(8'($urandom));
  endtask

  task add_header(input logic [15:0] qd, input logic [15:0] an);
    add_bytes(4);
    pkt.push_back(qd[15:8]);
    pkt.push_back(qd[7:0]);
    pkt.push_back(an[15:8]);
    pkt.push_back(an[7:0]);
    add_bytes(4);
  endtask

  task add_name(input int labels, input bit use_ptr);
    logic [7:0] len;
    repeat (labels) begin
      if ($urandom_range(0, 29) == 0) len = 8'($urandom_range(8'h40, 8'hBF));
      else len = 8'($urandom_range(1, 12));
      pkt.push_back(len);
      add_bytes(len);
    end
    if (use_ptr) begin
      pkt.push_back(PTR_MARK | 8'($urandom_range(0, 63)));
      add_bytes(1);
    end else begin
      pkt.push_back(8'd0);
    end
  endtask

  task add_record_head(input int labels, input bit use_ptr, input logic [15:0] rtype,
                       input logic [31:0] ttl, input logic [15:0] rdlen);
    add_name(labels, use_ptr);
    pkt.push_back(rtype[15:8]);
    pkt.push_back(rtype[7:0]);
    add_bytes(2);
    pkt.push_back(ttl[31:24]);
    pkt.push_back(ttl[23:16]);
    pkt.push_back(ttl[15:8]);
    pkt.push_back(ttl[7:0]);
    pkt.push_back(rdlen[15:8]);
    pkt.push_back(rdlen[7:0]);
  endtask

  task directed_packets();
    // lone byte that is also the last one
    pkt.push_back(8'h00);
    send_packet();
    // header only, no questions and no answers
    add_header(16'd0, 16'd0);
    send_packet();
    // no questions; zero TTL record ends on the packet's last byte
    add_header(16'd0, 16'd1);
    add_record_head(0, 1'b1, TYPE_A, 32'd0, 16'd4);
    add_bytes(4);
    send_packet();
    // long plain labels, pointer after labels, all-ones record, empty answer
    add_header(16'd1, 16'd2);
    pkt.push_back(8'h40);
    add_bytes(64);
    pkt.push_back(8'hBF);
    add_bytes(191);
    pkt.push_back(8'h00);
    add_bytes(4);
    add_record_head(2, 1'b1, TYPE_A, 32'hFFFF_FFFF, 16'd4);
    repeat (4) pkt.push_back(8'hFF);
    add_record_head(1, 1'b0, TYPE_A, 32'd1, 16'd0);
    add_bytes(5);
    send_packet();
    // wrong length, wrong type, saturating data count, zero address
    add_header(16'd2, 16'd4);
    add_name(0, 1'b1);
    add_bytes(4);
    add_name(1, 1'b1);
    add_bytes(4);
    add_record_head(0, 1'b1, TYPE_A, $urandom, 16'd5);
    add_bytes(5);
    add_record_head(0, 1'b1, TYPE_AAAA, $urandom, 16'd4);
    add_bytes(4);
    add_record_head(0, 1'b1, TYPE_A, $urandom, 16'd20);
    add_bytes(20);
    add_record_head(0, 1'b0, TYPE_A, $urandom, 16'd4);
    repeat (4) pkt.push_back(8'h00);
    send_packet();
    // all-ones counts, cut short inside the first question
    add_header(16'hFFFF, 16'hFFFF);
    add_bytes(6);
    send_packet();
  endtask

  task rand_packet();
    int          qd, an, mode, sel, cut;
    logic [15:0] rtype, rdlen;
    logic [31:0] ttl;
    qd   = $urandom_range(0, 2);
    an   = $urandom_range(0, 4);
    mode = $urandom_range(0, 15);
    if (mode == 0) begin
      // noise: random header counts, random body
      add_bytes($urandom_range(1, 40));
      send_packet();
      return;
    end
    // declare more answers than are sent so the packet ends early
    add_header(16'(qd), 16'(mode == 1 ? an + $urandom_range(1, 3) : an));
    repeat (qd) begin
      add_name($urandom_range(0, 3), $urandom_range(0, 3) == 0);
      add_bytes(4);
    end
    repeat (an) begin
      rtype = ($urandom_range(0, 3) != 0) ? TYPE_A : 16'($urandom);
      sel = $urandom_range(0, 9);
      if (sel < 7) rdlen = 16'd4;
      else if (sel == 7) rdlen = 16'd0;
      else if (sel == 8) rdlen = 16'($urandom_range(1, 6));
      else rdlen = 16'($urandom_range(14, 20));
      sel = $urandom_range(0, 9);
      if (sel == 0) ttl = 32'd0;
      else if (sel == 1) ttl = 32'hFFFF_FFFF;
      else ttl = $urandom;
      add_record_head($urandom_range(0, 2), $urandom_range(0, 1), rtype, ttl, rdlen);
      add_bytes(rdlen);
    end
    if (mode == 2) add_bytes($urandom_range(1, 8));
    if (mode == 3 || mode == 4) begin
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
    send_packet();
  endtask

  task wait_drained();
    int waited;
    waited = 0;
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (TailCycles) @(posedge clk);
  endtask

  initial begin
    logic [31:0] ttl_setting;
    int          target;
    int          base;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_access(1'b0, 32'd0);
    rx_idle_on <= 1'b1;
    directed_packets();
    wait_drained();
    // share the remaining byte budget evenly across the TTL settings
    base = bytes_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       ttl_setting = 32'd0;
        1:       ttl_setting = 32'hFFFF_FFFF;
        default: ttl_setting = $urandom;
      endcase
      cfg_access(1'b1, ttl_setting);
      cfg_access(1'b0, 32'd0);
      target = base + (ByteTarget - base) * (ph + 1) / 4;
      while (bytes_sent < target) begin
        // the final phase runs flat out on both sides
        tx_idle_on = (ph != 3) && ($urandom_range(0, 3) != 0);
        rx_idle_on <= (ph != 3) && ($urandom_range(0, 3) != 0);
        rand_packet();
        if (ph == 2) rx_hold_req <= 1'b1;
      end
      wait_drained();
    end
    $display("Run covered %0d bytes in %0d packets: %0d A records, %0d ended early.",
             bytes_sent, n_packets, n_records, n_truncated);
    $display("Default TTL took five settings with reads back; one long result hold-off.");
    if (failures == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * 2 * ClkHalf);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

@@ dns_answer_a_record_extractor_unit.f @@
hdl/dnsa_pkg.sv
hdl/dnsa_cfg_regs.sv
hdl/dnsa_in_stage.sv
hdl/dnsa_parser.sv
hdl/dns_answer_a_record_extractor_unit.sv
hdl/dnsa_checker.sv
bench/dnsa_result_checker.sv
bench/tb_dns_answer_a_record_extractor_unit.sv
